[hw/rtl/imhq_pkg.sv]
// Package for the indexed min-heap queue: beat structs, opcodes and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package imhq_pkg;
    localparam int unsigned TagW = 8;
    localparam int unsigned KeyW = 32;
    localparam int unsigned PayW = 32;
    localparam int unsigned CntW = 9;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_SET_KEY = 2'd1;
    localparam logic [1:0] OP_DEL_MIN = 2'd2;
    localparam logic [1:0] OP_REMOVE  = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [1:0]             opcode;
        logic [TagW-1:0]        item_id;
        logic signed [KeyW-1:0] key;
        logic [PayW-1:0]        payload;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]             status;
        logic [TagW-1:0]        out_id;
        logic signed [KeyW-1:0] out_key;
        logic [PayW-1:0]        out_payload;
        logic [CntW-1:0]        entry_total;
    } t_out_beat;
endpackage
`default_nettype wire

[hw/rtl/indexed_min_heap_queue.sv]
// Indexed binary min-heap: insert, set key, delete minimum and remove by id, one result
// beat per input beat. One beat is handled at a time. A sequencer with one slot-memory
// read port and one write port walks the heap one level per step. A step up reads the
// parent and compares; a step down reads both children, picks the smaller and compares.
// Slot lookup comes before the walk and wrap-up after it, where the operation needs them.
// The longest operation is delete minimum or remove sinking from the root to a leaf. The next
// input beat is taken only after the result beat has been accepted. Tag presence bits clear
// at reset. Slot and position memories need no clearing. Depends on imhq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_queue #(
    parameter int unsigned HEAP_DEPTH = 256
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  imhq_pkg::t_in_beat         i_in_data,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output imhq_pkg::t_out_beat        o_out_data,
    input  wire                        i_cfg_we,
    input  wire [imhq_pkg::CntW-1:0]   i_cfg_data
);
    localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int unsigned PW = AW + 1;
    localparam int unsigned LW = (PW > imhq_pkg::CntW) ? PW : imhq_pkg::CntW;
    localparam int unsigned TN = 1 << imhq_pkg::TagW;

    typedef struct packed {
        logic [imhq_pkg::TagW-1:0]        tag;
        logic signed [imhq_pkg::KeyW-1:0] key;
        logic [imhq_pkg::PayW-1:0]        pay;
    } t_ent;

    typedef enum logic [3:0] {
        S_IDLE, S_LOOK, S_LAST, S_FIX, S_CHK_L, S_CHK_R, S_UP_RD, S_UP_CMP,
        S_DN_RD, S_DN_L, S_DN_R, S_DN_CMP, S_PLACE, S_DONE
    } t_state;

    function automatic logic key_lt(input logic [imhq_pkg::KeyW-1:0] a,
                                    input logic [imhq_pkg::KeyW-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    t_ent                  r_mem [HEAP_DEPTH];
    logic [AW-1:0]         r_pos_mem [TN];
    logic [TN-1:0]         r_present;
    t_ent                  r_rd;
    logic [AW-1:0]         r_pos_rd;

    t_state                r_state;
    logic [imhq_pkg::CntW-1:0] r_limit;
    logic [PW-1:0]         r_count;
    logic [PW-1:0]         r_pos;
    logic [PW-1:0]         r_child;
    t_ent                  r_cur;
    t_ent                  r_lkid;
    logic                  r_pos0;
    imhq_pkg::t_in_beat    r_op;
    imhq_pkg::t_out_beat   r_res;

    // memory port control
    logic          n_re;
    logic [AW-1:0] n_ra;
    logic          n_we;
    logic [AW-1:0] n_wa;
    t_ent          n_wd;
    logic [imhq_pkg::TagW-1:0] pos_ra;

    // accept decision
    logic [2:0]    acc_status;
    t_state        acc_next;

    logic [PW:0]   lkid, rkid, cnt_x;
    logic [PW-1:0] parent, last;
    logic [LW-1:0] lim_w;
    logic [PW-1:0] limit_eff;
    assign lkid   = {r_pos, 1'b1};
    assign rkid   = lkid + (PW+1)'(1);
    assign cnt_x  = {1'b0, r_count};
    assign parent = (r_pos - PW'(1)) >> 1;
    assign last   = r_count - PW'(1);
    assign lim_w  = LW'(r_limit);
    assign limit_eff = (lim_w > LW'(HEAP_DEPTH)) ? PW'(HEAP_DEPTH) : PW'(r_limit);

    // position lookup starts on the accepting edge
    assign pos_ra = (r_state == S_IDLE) ? i_in_data.item_id : r_op.item_id;

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_wa] <= n_wd;
        if (n_re) r_rd <= r_mem[n_ra];
        if (n_we) r_pos_mem[n_wd.tag] <= n_wa;
        r_pos_rd <= r_pos_mem[pos_ra];
    end

    assign o_in_ready = (r_state == S_IDLE) && !o_out_valid;

    always_comb begin
        acc_status = imhq_pkg::ST_OK;
        acc_next   = S_LOOK;
        unique case (i_in_data.opcode)
            imhq_pkg::OP_INSERT: begin
                if (r_count >= limit_eff) begin
                    acc_status = imhq_pkg::ST_FULL; acc_next = S_DONE;
                end else if (r_present[i_in_data.item_id]) begin
                    acc_status = imhq_pkg::ST_DUP; acc_next = S_DONE;
                end else acc_next = S_UP_RD;
            end
            imhq_pkg::OP_DEL_MIN: if (r_count == '0) begin
                acc_status = imhq_pkg::ST_EMPTY; acc_next = S_DONE;
            end
            default: if (!r_present[i_in_data.item_id]) begin
                acc_status = imhq_pkg::ST_NOTFOUND; acc_next = S_DONE;
            end
        endcase
    end

    always_comb begin
        n_re = 1'b0; n_ra = '0; n_we = 1'b0; n_wa = '0; n_wd = r_cur;
        unique case (r_state)
            S_LOOK: begin
                n_re = 1'b1;
                n_ra = (r_op.opcode == imhq_pkg::OP_DEL_MIN) ? '0 : r_pos_rd;
            end
            S_LAST:   begin n_re = 1'b1; n_ra = last[AW-1:0]; end
            S_FIX:    begin n_re = 1'b1; n_ra = lkid[AW-1:0]; end
            S_CHK_L:  begin n_re = 1'b1; n_ra = rkid[AW-1:0]; end
            S_UP_RD:  begin n_re = 1'b1; n_ra = parent[AW-1:0]; end
            S_DN_RD:  begin n_re = 1'b1; n_ra = lkid[AW-1:0]; end
            S_DN_L:   begin n_re = 1'b1; n_ra = rkid[AW-1:0]; end
            S_UP_CMP: if (r_pos != '0 && key_lt(r_cur.key, r_rd.key)) begin
                n_we = 1'b1; n_wa = r_pos[AW-1:0]; n_wd = r_rd;
            end
            S_DN_CMP: if (key_lt(r_lkid.key, r_cur.key)) begin
                n_we = 1'b1; n_wa = r_pos[AW-1:0]; n_wd = r_lkid;
            end
            S_PLACE:  begin n_we = 1'b1; n_wa = r_pos[AW-1:0]; n_wd = r_cur; end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= imhq_pkg::CntW'(256);
            r_count     <= '0;
            r_present   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (r_state == S_DONE) o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid && o_in_ready) begin
                    r_op  <= i_in_data;
                    r_res <= '{status: acc_status,
                               out_id: (i_in_data.opcode == imhq_pkg::OP_DEL_MIN)
                                       ? '0 : i_in_data.item_id,
                               out_key: '0, out_payload: '0, entry_total: '0};
                    r_state <= acc_next;
                    if (acc_next == S_UP_RD) begin
                        r_present[i_in_data.item_id] <= 1'b1;
                        r_cur <= '{tag: i_in_data.item_id, key: i_in_data.key,
                                   pay: i_in_data.payload};
                        r_pos <= r_count;
                        r_count <= r_count + PW'(1);
                    end
                end
                S_LOOK: begin
                    // position read is registered; fetch the addressed slot
                    r_pos <= (r_op.opcode == imhq_pkg::OP_DEL_MIN) ? '0 : PW'(r_pos_rd);
                    r_state <= (r_op.opcode == imhq_pkg::OP_SET_KEY) ? S_FIX : S_LAST;
                end
                S_LAST: begin
                    // r_rd holds the slot being taken out
                    r_res.out_id <= (r_op.opcode == imhq_pkg::OP_DEL_MIN)
                                    ? r_rd.tag : r_op.item_id;
                    r_res.out_key     <= r_rd.key;
                    r_res.out_payload <= r_rd.pay;
                    r_present[r_rd.tag] <= 1'b0;
                    r_count <= last;
                    r_state <= (r_pos == last) ? S_DONE : S_FIX;
                end
                S_FIX: begin
                    // r_rd: set-key slot or the last slot moving into the hole
                    if (r_op.opcode == imhq_pkg::OP_SET_KEY)
                        r_cur <= '{tag: r_rd.tag, key: r_op.key, pay: r_rd.pay};
                    else
                        r_cur <= r_rd;
                    r_pos0 <= (r_pos == '0);
                    r_state <= S_CHK_L;
                end
                S_CHK_L: begin
                    r_lkid  <= r_rd;
                    r_state <= S_CHK_R;
                end
                S_CHK_R: begin
                    if (r_pos0 || (lkid < cnt_x && key_lt(r_lkid.key, r_cur.key)) ||
                        (rkid < cnt_x && key_lt(r_rd.key, r_cur.key))) begin
                        if (lkid >= cnt_x) r_state <= S_PLACE;
                        else begin
                            if (rkid < cnt_x && key_lt(r_rd.key, r_lkid.key)) begin
                                r_lkid <= r_rd; r_child <= rkid[PW-1:0];
                            end else r_child <= lkid[PW-1:0];
                            r_state <= S_DN_CMP;
                        end
                    end else r_state <= S_UP_RD;
                end
                S_UP_RD: r_state <= (r_pos == '0) ? S_PLACE : S_UP_CMP;
                S_UP_CMP: begin
                    if (key_lt(r_cur.key, r_rd.key)) begin
                        r_pos <= parent; r_state <= S_UP_RD;
                    end else r_state <= S_PLACE;
                end
                S_DN_RD: r_state <= S_DN_L;
                S_DN_L: begin
                    r_lkid <= r_rd;
                    r_state <= S_DN_R;
                end
                S_DN_R: begin
                    if (rkid < cnt_x && key_lt(r_rd.key, r_lkid.key)) begin
                        r_lkid <= r_rd; r_child <= rkid[PW-1:0];
                    end else r_child <= lkid[PW-1:0];
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (key_lt(r_lkid.key, r_cur.key)) begin
                        r_pos <= r_child;
                        r_state <= ({r_child, 1'b1} < cnt_x) ? S_DN_RD : S_PLACE;
                    end else r_state <= S_PLACE;
                end
                S_PLACE: r_state <= S_DONE;
                S_DONE: begin
                    o_out_data <= '{status: r_res.status, out_id: r_res.out_id,
                                    out_key: r_res.out_key, out_payload: r_res.out_payload,
                                    entry_total: imhq_pkg::CntW'(r_count)};
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
